// ===== rtl/dil_pkg.sv =====
`default_nettype none
package dil_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int FRAME_LEN   = 17;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ELEMENT = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_DIL_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SEQ1_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SEQ2_LENGTH = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] position_value;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [7:0] dil_count;
    logic [7:0] seq1_length;
    logic [7:0] seq2_length;
  } cfg_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_BYTE  = 2'd1,
    JOB_FIELD = 2'd2
  } job_kind_t;

  // flag: last byte of a sequence, or odd field (closes the frame)
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] value;
    logic       flag;
    logic       tail;
  } job_t;

  typedef struct packed {
    logic avail;
    logic full;
  } queue_stat_t;

endpackage
`default_nettype wire

// ===== rtl/dil_queue.sv =====
`default_nettype none
module dil_queue #(
  parameter int Depth = dil_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  dil_pkg::job_t       wdata,
  input  wire                 pop,
  output dil_pkg::job_t       rdata,
  output dil_pkg::queue_stat_t stat
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  dil_pkg::job_t mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign rdata      = mem[rd_ptr];
  assign stat.avail = (count != '0);
  assign stat.full  = (count == CntW'(Depth));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dil_front.sv =====
`default_nettype none
module dil_front (
  input  wire                  clk,
  input  wire                  rst,
  input  dil_pkg::cfg_t        cfg,
  input  wire                  item_valid,
  output logic                 item_ready,
  input  dil_pkg::in_t         item,
  input  dil_pkg::queue_stat_t stat,
  output logic                 push,
  output dil_pkg::job_t        job
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SEQ1 = 5'b00010,
    PH_SEQ2 = 5'b00100,
    PH_SEG  = 5'b01000,
    PH_DIL  = 5'b10000
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] element_counter, element_counter_next;
  logic       accept;
  logic [7:0] seq_len;
  logic [8:0] ec_inc;
  logic [8:0] dil_sum;
  logic [8:0] dil_total;
  phase_t     after_seq1;

  assign item_ready = !stat.full;
  assign accept     = item_valid && item_ready;
  assign seq_len    = (phase == PH_SEQ1) ? cfg.seq1_length : cfg.seq2_length;
  assign ec_inc     = {1'b0, element_counter} + 9'd1;
  assign dil_sum    = {1'b0, cfg.dil_count} + 9'd1;
  assign dil_total  = {dil_sum[8:1], 1'b0};
  assign after_seq1 = (cfg.seq2_length != 8'd0) ? PH_SEQ2 : PH_SEG;

  always_comb begin
    phase_next           = phase;
    element_counter_next = element_counter;
    push                 = 1'b0;
    job.kind             = dil_pkg::JOB_START;
    job.value            = item.value;
    job.flag             = 1'b0;
    job.tail             = 1'b0;
    if (accept) begin
      if (item.command == dil_pkg::CMD_START) begin
        push                 = 1'b1;
        element_counter_next = 8'd0;
        phase_next           = (cfg.seq1_length != 8'd0) ? PH_SEQ1 : after_seq1;
      end else begin
        unique case (phase)
          PH_SEQ1, PH_SEQ2: begin
            push     = 1'b1;
            job.kind = dil_pkg::JOB_BYTE;
            job.flag = (ec_inc >= {1'b0, seq_len});
            if (job.flag) begin
              element_counter_next = 8'd0;
              phase_next           = (phase == PH_SEQ1) ? after_seq1 : PH_SEG;
            end else begin
              element_counter_next = ec_inc[7:0];
            end
          end
          PH_SEG: begin
            push     = 1'b1;
            job.kind = dil_pkg::JOB_FIELD;
            job.flag = element_counter[0];
            if (element_counter >= 8'd15) begin
              element_counter_next = 8'd0;
              if (cfg.dil_count != 8'd0) begin
                phase_next = PH_DIL;
              end else begin
                job.tail   = 1'b1;
                phase_next = PH_IDLE;
              end
            end else begin
              element_counter_next = ec_inc[7:0];
            end
          end
          PH_DIL: begin
            push     = 1'b1;
            job.kind = dil_pkg::JOB_FIELD;
            job.flag = element_counter[0];
            if (element_counter[0] && (ec_inc >= dil_total)) begin
              job.tail             = 1'b1;
              phase_next           = PH_IDLE;
              element_counter_next = 8'd0;
            end else begin
              element_counter_next = ec_inc[7:0];
            end
          end
          PH_IDLE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      element_counter <= 8'd0;
    end else begin
      phase           <= phase_next;
      element_counter <= element_counter_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dil_back.sv =====
`default_nettype none
module dil_back (
  input  wire                  clk,
  input  wire                  rst,
  input  dil_pkg::cfg_t        cfg,
  input  dil_pkg::queue_stat_t stat,
  input  dil_pkg::job_t        job_in,
  output logic                 pop,
  output logic                 busy,
  output logic                 result_valid,
  input  wire                  result_ready,
  output dil_pkg::out_t        result
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_START    = 7'b0000010,
    ST_BYTE     = 7'b0000100,
    ST_BYTE_VAL = 7'b0001000,
    ST_PAD      = 7'b0010000,
    ST_FIELD    = 7'b0100000,
    ST_TAIL     = 7'b1000000
  } state_t;

  state_t        state, state_next, load_state;
  dil_pkg::job_t job;
  logic [5:0]    cnt, cnt_next;
  logic [11:0]   stream_position;
  logic [4:0]    frame_offset;
  logic [15:0]   crc_register;

  logic       fire;
  logic       done;
  logic [7:0] e_val;
  logic       e_feed;
  logic       e_last;
  logic       load;
  logic       crc_fb;
  logic [7:0] seq1_m1;
  logic [7:0] seq2_m1;
  logic [5:0] d_idx;
  logic [5:0] s1_idx;
  logic [5:0] s2_idx;
  logic [5:0] crc_idx;

  assign busy    = (state != ST_IDLE);
  assign fire    = busy && (!result_valid || result_ready);
  assign seq1_m1 = cfg.seq1_length - 8'd1;
  assign seq2_m1 = cfg.seq2_length - 8'd1;
  assign d_idx   = cnt - 6'd18;
  assign s1_idx  = cnt - 6'd35;
  assign s2_idx  = cnt - 6'd43;
  assign crc_idx = cnt - 6'd34;

  always_comb begin
    e_val      = 8'd0;
    e_feed     = 1'b1;
    e_last     = 1'b0;
    done       = 1'b0;
    state_next = state;
    cnt_next   = cnt + 6'd1;
    unique case (state)
      ST_START: begin
        priority if (cnt <= 6'd16) e_val[0] = 1'b1;
        else if (cnt >= 6'd18 && cnt <= 6'd25) e_val[0] = cfg.dil_count[d_idx[2:0]];
        else if (cnt >= 6'd35 && cnt <= 6'd41) e_val[0] = seq1_m1[s1_idx[2:0]];
        else if (cnt >= 6'd43 && cnt <= 6'd49) e_val[0] = seq2_m1[s2_idx[2:0]];
        else e_val[0] = 1'b0;
        done = (cnt == 6'd51);
      end
      ST_BYTE: begin
        if (frame_offset == 5'd0) begin
          state_next = ST_BYTE_VAL;
        end else begin
          e_val = job.value;
          if (job.flag) state_next = ST_PAD;
          else done = 1'b1;
        end
      end
      ST_BYTE_VAL: begin
        e_val = job.value;
        if (job.flag) state_next = ST_PAD;
        else done = 1'b1;
      end
      ST_PAD: begin
        done = (frame_offset == 5'd0);
      end
      ST_FIELD: begin
        if (cnt <= 6'd6) e_val[0] = job.value[cnt[2:0]];
        if ((cnt == 6'd7 && !job.flag) || cnt == 6'd8) begin
          if (job.tail) begin
            state_next = ST_TAIL;
            cnt_next   = 6'd0;
          end else begin
            done = 1'b1;
          end
        end
      end
      ST_TAIL: begin
        e_feed = (cnt <= 6'd33);
        priority if (cnt <= 6'd15) e_val[0] = 1'b1;
        else if (cnt >= 6'd34 && cnt <= 6'd49) e_val[0] = crc_register[crc_idx[3:0]];
        else e_val[0] = 1'b0;
        if (cnt == 6'd50) begin
          e_last = stream_position[0];
          done   = stream_position[0];
        end else if (cnt == 6'd51) begin
          e_last = 1'b1;
          done   = 1'b1;
        end
      end
      ST_IDLE: begin
      end
      default: begin
      end
    endcase
  end

  assign load = stat.avail && (!busy || (fire && done));
  assign pop  = load;

  always_comb begin
    unique case (job_in.kind)
      dil_pkg::JOB_START: load_state = ST_START;
      dil_pkg::JOB_BYTE:  load_state = ST_BYTE;
      dil_pkg::JOB_FIELD: load_state = ST_FIELD;
      default:            load_state = ST_IDLE;
    endcase
  end

  assign crc_fb = e_val[0] ^ crc_register[0];

  always_ff @(posedge clk) begin
    if (fire) begin
      result.position_value <= e_val;
      result.last           <= e_last;
    end
    if (load) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= 6'd0;
      result_valid    <= 1'b0;
      stream_position <= 12'd0;
      frame_offset    <= 5'd0;
      crc_register    <= 16'hFFFF;
    end else begin
      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (load && job_in.kind == dil_pkg::JOB_START) begin
        stream_position <= 12'd0;
        frame_offset    <= 5'd0;
        crc_register    <= 16'hFFFF;
      end else if (fire) begin
        if (e_feed && stream_position >= 12'(dil_pkg::FRAME_LEN) && frame_offset != 5'd0) begin
          crc_register <= {1'b0, crc_register[15:1]} ^ (crc_fb ? 16'h8408 : 16'h0000);
        end
        stream_position <= stream_position + 12'd1;
        frame_offset    <= (frame_offset >= 5'(dil_pkg::FRAME_LEN - 1)) ? 5'd0
                                                                         : frame_offset + 5'd1;
      end
      if (load) begin
        state <= load_state;
        cnt   <= 6'd0;
      end else if (fire) begin
        if (!done) begin
          state <= state_next;
          cnt   <= cnt_next;
        end else begin
          state <= ST_IDLE;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dil_descriptor_framer_crc16.sv =====
// Output: one stream position per cycle from the serializer, held while the receiver stalls.
// The input side keeps accepting while the job queue has room.
// Reset (rst, synchronous): descriptor idle, queue empty, no result pending,
//   dil_count 0, seq1_length 1, seq2_length 1, CRC register all ones.
`default_nettype none
module dil_descriptor_framer_crc16 #(
  parameter int QueueDepth = dil_pkg::QUEUE_DEPTH
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                item_valid,
  output logic                               item_ready,
  input  dil_pkg::in_t                       item,
  output logic                               result_valid,
  input  wire                                result_ready,
  output dil_pkg::out_t                      result,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [dil_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [7:0]                         cfg_data
);

  dil_pkg::cfg_t        cfg;
  dil_pkg::queue_stat_t qstat;
  dil_pkg::job_t        push_job;
  dil_pkg::job_t        head_job;
  logic                 push;
  logic                 pop;
  logic                 back_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dil_count   <= 8'd0;
      cfg.seq1_length <= 8'd1;
      cfg.seq2_length <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dil_pkg::REG_DIL_COUNT:   cfg.dil_count   <= cfg_data;
        dil_pkg::REG_SEQ1_LENGTH: cfg.seq1_length <= cfg_data;
        dil_pkg::REG_SEQ2_LENGTH: cfg.seq2_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dil_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .stat       (qstat),
    .push       (push),
    .job        (push_job)
  );

  dil_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (pop),
    .rdata (head_job),
    .stat  (qstat)
  );

  dil_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .stat         (qstat),
    .job_in       (head_job),
    .pop          (pop),
    .busy         (back_busy),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.avail)
    else $error("queue popped while empty");

  a_start_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.command == dil_pkg::CMD_START
     && !qstat.avail && !back_busy) |=> ##2 result_valid)
    else $error("start transfer produced no result");

  a_last_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> (result.position_value == 8'd0))
    else $error("final position is not a zero");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/dil_descriptor_framer_crc16_checker.sv =====
`default_nettype none
module dil_descriptor_framer_crc16_checker
  import dil_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  input  wire                    item_ready,
  input  in_t                    item,
  input  wire                    result_valid,
  input  wire                    result_ready,
  input  out_t                   result,
  input  wire                    cfg_valid,
  input  wire                    cfg_ready,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [7:0]             cfg_data,
  output int                     errors,
  output int                     pending,
  output int                     positions,
  output int                     descriptors
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          MAX_POS_PER_ITEM = 61;
  localparam logic [15:0] CRC_POLY_REFL    = 16'h8408;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_SEQ1,
    DP_SEQ2,
    DP_SEGMENTS,
    DP_DIL_CODES
  } desc_phase_t;

  logic [7:0]  cur_dil;
  logic [7:0]  cur_seq1;
  logic [7:0]  cur_seq2;
  desc_phase_t dphase;
  logic [7:0]  elem_idx;
  logic [11:0] slot_count;
  logic [4:0]  frame_slot;
  logic [15:0] crc_acc;
  int          item_pos_count;
  out_t        expected_positions[$];

  initial begin
    errors      = 0;
    positions   = 0;
    descriptors = 0;
    pending     = 0;
  end

  task automatic put_position(input logic [7:0] v, input bit feed);
    out_t o;
    logic fb;
    if (item_pos_count < MAX_POS_PER_ITEM) begin
      o.position_value = v;
      o.last           = 1'b0;
      expected_positions.push_back(o);
      item_pos_count++;
    end
    if (feed && slot_count >= FRAME_LEN && frame_slot != 0) begin
      fb      = v[0] ^ crc_acc[0];
      crc_acc = (crc_acc >> 1) ^ (fb ? CRC_POLY_REFL : 16'h0000);
    end
    slot_count = slot_count + 12'd1;
    frame_slot = (frame_slot >= FRAME_LEN - 1) ? 5'd0 : frame_slot + 5'd1;
  endtask

  task automatic put_bits(input logic [16:0] v, input int count, input bit feed);
    for (int i = 0; i < count; i++) put_position({7'd0, v[i]}, feed);
  endtask

  task automatic put_field(input logic [7:0] v, input bit close_frame);
    put_bits({10'd0, v[6:0]}, 7, 1'b1);
    put_position(8'd0, 1'b1);
    if (close_frame) put_position(8'd0, 1'b1);
  endtask

  task automatic put_tail();
    logic [15:0] crc_snap;
    out_t        o;
    put_bits(17'h0FFFF, 16, 1'b1);
    put_position(8'd0, 1'b1);
    put_bits(17'h00000, 16, 1'b1);
    put_position(8'd0, 1'b1);
    crc_snap = crc_acc;
    put_bits({1'b0, crc_snap}, 16, 1'b0);
    put_position(8'd0, 1'b0);
    if (slot_count[0]) put_position(8'd0, 1'b0);
    o      = expected_positions.pop_back();
    o.last = 1'b1;
    expected_positions.push_back(o);
    dphase   = DP_IDLE;
    elem_idx = 8'd0;
  endtask

  task automatic leave_seq1();
    elem_idx = 8'd0;
    dphase   = (cur_seq2 != 0) ? DP_SEQ2 : DP_SEGMENTS;
  endtask

  task automatic frame_item(input in_t it);
    logic [7:0] seq_len;
    bit         was_framing;
    bit         odd;
    int         dil_total;
    item_pos_count = 0;
    if (it.command == CMD_START) begin
      slot_count = 12'd0;
      frame_slot = 5'd0;
      crc_acc    = 16'hFFFF;
      put_bits(17'h1FFFF, 17, 1'b1);
      put_position(8'd0, 1'b1);
      put_bits({9'd0, cur_dil}, 8, 1'b1);
      put_bits(17'h00000, 8, 1'b1);
      put_position(8'd0, 1'b1);
      put_field(cur_seq1 - 8'd1, 1'b0);
      put_field(cur_seq2 - 8'd1, 1'b1);
      elem_idx = 8'd0;
      if (cur_seq1 != 0) dphase = DP_SEQ1;
      else leave_seq1();
    end else begin
      case (dphase)
        DP_SEQ1, DP_SEQ2: begin
          seq_len = (dphase == DP_SEQ1) ? cur_seq1 : cur_seq2;
          if (frame_slot == 0) put_position(8'd0, 1'b1);
          put_position(it.value, 1'b1);
          if (int'(elem_idx) + 1 >= int'(seq_len)) begin
            do begin
              was_framing = (frame_slot == 0);
              put_position(8'd0, 1'b1);
            end while (!was_framing);
            if (dphase == DP_SEQ1) begin
              leave_seq1();
            end else begin
              elem_idx = 8'd0;
              dphase   = DP_SEGMENTS;
            end
          end else begin
            elem_idx = elem_idx + 8'd1;
          end
        end
        DP_SEGMENTS: begin
          odd = elem_idx[0];
          put_field(it.value, odd);
          if (elem_idx >= 8'd15) begin
            elem_idx = 8'd0;
            if (cur_dil != 0) dphase = DP_DIL_CODES;
            else put_tail();
          end else begin
            elem_idx = elem_idx + 8'd1;
          end
        end
        DP_DIL_CODES: begin
          odd       = elem_idx[0];
          dil_total = (int'(cur_dil) + 1) & ~1;
          put_field(it.value, odd);
          if (odd && int'(elem_idx) + 1 >= dil_total) put_tail();
          else elem_idx = elem_idx + 8'd1;
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      cur_dil    = 8'd0;
      cur_seq1   = 8'd1;
      cur_seq2   = 8'd1;
      dphase     = DP_IDLE;
      elem_idx   = 8'd0;
      slot_count = 12'd0;
      frame_slot = 5'd0;
      crc_acc    = 16'hFFFF;
      expected_positions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DIL_COUNT:   cur_dil  = cfg_data;
          REG_SEQ1_LENGTH: cur_seq1 = cfg_data;
          REG_SEQ2_LENGTH: cur_seq2 = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && item_ready) frame_item(item);
      if (result_valid && result_ready) begin
        positions++;
        if (result.last) descriptors++;
        if (expected_positions.size() == 0) begin
          errors++;
          $display("%0t unexpected position: expected none, actual value %0d last %0b",
                   $time, result.position_value, result.last);
        end else begin
          want = expected_positions.pop_front();
          if (want.position_value !== result.position_value) begin
            errors++;
            $display("%0t position_value mismatch: expected %0d, actual %0d",
                     $time, want.position_value, result.position_value);
          end
          if (want.last !== result.last) begin
            errors++;
            $display("%0t last mismatch: expected %0b, actual %0b",
                     $time, want.last, result.last);
          end
        end
      end
    end
    pending <= expected_positions.size();
  end

endmodule
`default_nettype wire

// ===== tb/sv/dil_descriptor_framer_crc16_tb.sv =====
`default_nettype none
module dil_descriptor_framer_crc16_tb;
  import dil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS  = 410;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 20;

  logic                   clk;
  logic                   rst;
  logic                   item_valid;
  logic                   item_ready;
  in_t                    item;
  logic                   result_valid;
  logic                   result_ready;
  out_t                   result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;

  int errors;
  int pending;
  int positions;
  int descriptors;

  int idle_pct;
  int stall_pct;
  int sent;
  int total;
  int quiet;
  bit shaping;
  bit hold_req;
  bit hold_done;

  logic [7:0]             corner_vals [4] = '{8'h7F, 8'h80, 8'hFF, 8'h00};
  logic [CFG_INDEX_W-1:0] reg_order   [3] = '{REG_DIL_COUNT, REG_SEQ1_LENGTH, REG_SEQ2_LENGTH};

  dil_descriptor_framer_crc16 i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  dil_descriptor_framer_crc16_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending),
    .positions    (positions),
    .descriptors  (descriptors)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, quiet);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver; one long hold-off on request so the input side backs up
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] v, input bit counts);
    if (shaping) begin
      if (sent < RANDOM_ITEMS / 4) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if (sent < RANDOM_ITEMS / 2) begin
        idle_pct  = 66;
        stall_pct = 0;
      end else if (sent < 3 * RANDOM_ITEMS / 4) begin
        idle_pct  = 0;
        stall_pct = 66;
      end else begin
        idle_pct  = 23;
        stall_pct = 23;
      end
    end
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {cmd, v};
    do @(posedge clk); while (!item_ready);
    total++;
    if (counts) sent++;
  endtask

  // sender pause: every predicted position delivered, then a settling wait
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dil, input logic [7:0] s1, input logic [7:0] s2);
    logic [7:0] vals [3];
    vals[0] = dil;
    vals[1] = s1;
    vals[2] = s2;
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= reg_order[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int  s1;
    int  s2;
    int  dil;
    int  need;
    bit  cut;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst        = 1'b1;
    quiet      = 0;
    idle_pct   = 0;
    stall_pct  = 0;
    sent       = 0;
    total      = 0;
    shaping    = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    idle_pct  = 23;
    stall_pct = 23;
    // element before any start: ignored
    send_item(CMD_ELEMENT, 8'h5A, 1'b0);
    drain();
    // reset config: one byte per sequence, no DIL codes
    send_item(CMD_START, 8'h00, 1'b0);
    send_item(CMD_ELEMENT, 8'hFF, 1'b0);
    send_item(CMD_ELEMENT, 8'h00, 1'b0);
    for (int i = 0; i < 16; i++) send_item(CMD_ELEMENT, corner_vals[i % 4], 1'b0);
    // element after completion: ignored
    send_item(CMD_ELEMENT, 8'hC3, 1'b0);
    drain();
    // both sequences empty, full DIL count
    set_config(8'd255, 8'd0, 8'd0);
    send_item(CMD_START, 8'hFF, 1'b0);
    send_item(CMD_ELEMENT, 8'h55, 1'b0);
    drain();
    set_config(8'd0, 8'd128, 8'd128);
    send_item(CMD_START, 8'h00, 1'b0);
    send_item(CMD_ELEMENT, 8'hAA, 1'b0);

    shaping = 1'b1;
    s1  = 1;
    s2  = 1;
    dil = 0;
    for (int d = 0; sent < RANDOM_ITEMS; d++) begin
      if (d < 8 || $urandom_range(1) == 0) begin
        s1  = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(3);
        s2  = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(3);
        dil = ($urandom_range(3) == 0) ? $urandom_range(12) : $urandom_range(3);
        if (d == 2) dil = 255;
        if (d == 5) begin
          if ($urandom_range(1) == 0) s1 = 128;
          else s2 = 128;
        end
        drain();
        set_config(dil[7:0], s1[7:0], s2[7:0]);
      end
      need = s1 + s2 + 16 + ((dil + 1) & ~1);
      cut  = (d != 2 && d != 5 && $urandom_range(7) == 0);
      if (cut) need = $urandom_range(need - 1);
      if (d == 1) hold_req = 1'b1;
      send_item(CMD_START, 8'($urandom_range(255)), 1'b1);
      for (int k = 0; k < need; k++) send_item(CMD_ELEMENT, 8'($urandom_range(255)), 1'b1);
      if (!cut && $urandom_range(3) == 0) begin
        repeat ($urandom_range(3, 1)) send_item(CMD_ELEMENT, 8'($urandom_range(255)), 1'b0);
      end
    end

    shaping = 1'b0;
    drain();
    $display("Covered %0d item transfers (%0d random) over four pacing modes and a long hold-off,",
             total, sent);
    $display("%0d stream positions compared, %0d descriptors framed through the CRC frame.",
             positions, descriptors);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/dil_pkg.sv
rtl/dil_queue.sv
rtl/dil_front.sv
rtl/dil_back.sv
rtl/dil_descriptor_framer_crc16.sv
tb/sv/dil_descriptor_framer_crc16_checker.sv
tb/sv/dil_descriptor_framer_crc16_tb.sv
